FILE: rtl/cqsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqsa_pkg: shared types and constants of the quota slot allocator
// slot pool sizing, opcodes, kind codes, beat layouts and the
// command and status groups between the controller and the datapath
// ----------------------------------------------------------------------------
package cqsa_pkg;

    localparam int POOL_SLOTS  = 8;
    localparam int HANDLE_BITS = 16;
    localparam int SLOT_W      = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int CNT_W       = $clog2(POOL_SLOTS + 1);
    localparam int QUOTA_W     = 4;
    localparam int CMP_W       = (CNT_W > QUOTA_W) ? CNT_W : QUOTA_W;
    localparam int ORDER_W     = 16;
    localparam int OP_W        = 2;
    localparam int KIND_W      = 2;

    // input beat: op, kind, handle
    localparam int S_FIELD_W = OP_W + KIND_W + HANDLE_BITS;
    localparam int S_DATA_W  = ((S_FIELD_W + 7) / 8) * 8;
    // result beat: ok, slot_index, evicted, evicted_handle
    localparam int M_FIELD_W = 1 + SLOT_W + 1 + HANDLE_BITS;
    localparam int M_DATA_W  = ((M_FIELD_W + 7) / 8) * 8;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;
    localparam logic [OP_W-1:0] OP_QUERY   = 2'd3;

    localparam logic [KIND_W-1:0] KIND_STATUE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BLOCK    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PLATFORM = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE     = 2'd3;

    localparam logic [1:0] REG_QUOTA_STATUE   = 2'd0;
    localparam logic [1:0] REG_QUOTA_BLOCK    = 2'd1;
    localparam logic [1:0] REG_QUOTA_PLATFORM = 2'd2;

    localparam logic [QUOTA_W-1:0] QUOTA_STATUE_RST   = 4'd2;
    localparam logic [QUOTA_W-1:0] QUOTA_BLOCK_RST    = 4'd3;
    localparam logic [QUOTA_W-1:0] QUOTA_PLATFORM_RST = 4'd3;

    typedef struct packed {
        logic [QUOTA_W-1:0] statue;
        logic [QUOTA_W-1:0] block;
        logic [QUOTA_W-1:0] platform;
    } quota_t;

    typedef struct packed {
        logic start;   // latch request, clear scan state
        logic step;    // examine one slot
        logic commit;  // update pool, load result
    } dp_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } dp_status_t;

endpackage

FILE: rtl/class_quota_slot_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// class_quota_slot_allocator_unit: per-kind quota slot allocator
// keeps a pool of slots with owner handles, grants, evicts oldest per
// kind, releases and looks up by handle; quotas set over an apb port
// ----------------------------------------------------------------------------
// A request beat is handled in order: the request is captured, the pool is
// walked slot by slot through the single scan step of the datapath, and a
// commit updates the pool and loads the result register. s_tready is high
// while the sequencer is idle, and the next request may be accepted while the
// previous result still waits on m_tready; a commit only stalls when the
// result register is still full. Results of failed requests, release/query
// misses and clear all are all-zero beats. Quota registers live at byte
// addresses 0x0 (statue), 0x4 (block) and 0x8 (platform), bits [3:0]; write
// them only while idle. Handles are compared as full words, and duplicates
// are not rejected: release and query act on the lowest slot holding the
// handle.
// ----------------------------------------------------------------------------
module class_quota_slot_allocator_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // request beat, bits from low: op[1:0], kind[3:2], handle[19:4]
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cqsa_pkg::S_DATA_W-1:0]     s_tdata,
    // result beat, bits from low: ok[0], slot_index[3:1], evicted[4],
    // evicted_handle[20:5]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [cqsa_pkg::M_DATA_W-1:0]     m_tdata,
    // quota register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cqsa_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [cqsa_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [cqsa_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import cqsa_pkg::*;

    quota_t     quota_reg;
    dp_cmd_t    cmd;
    dp_status_t status;
    logic       cfg_wr;
    logic [1:0] reg_sel;

    // register index sits above the byte offset
    assign reg_sel = paddr[3:2];
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quota_reg.statue   <= QUOTA_STATUE_RST;
            quota_reg.block    <= QUOTA_BLOCK_RST;
            quota_reg.platform <= QUOTA_PLATFORM_RST;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_QUOTA_STATUE:   quota_reg.statue   <= pwdata[QUOTA_W-1:0];
                REG_QUOTA_BLOCK:    quota_reg.block    <= pwdata[QUOTA_W-1:0];
                REG_QUOTA_PLATFORM: quota_reg.platform <= pwdata[QUOTA_W-1:0];
                default:            quota_reg          <= quota_reg;
            endcase
        end
    end

    // read back, unused addresses read zero
    always_comb begin
        unique case (reg_sel)
            REG_QUOTA_STATUE:   prdata = APB_DATA_W'(quota_reg.statue);
            REG_QUOTA_BLOCK:    prdata = APB_DATA_W'(quota_reg.block);
            REG_QUOTA_PLATFORM: prdata = APB_DATA_W'(quota_reg.platform);
            default:            prdata = '0;
        endcase
    end

    // sequencer: idle, scan over slots, commit
    cqsa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // pool, scan accumulators and result register
    cqsa_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .quota    (quota_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: rtl/cqsa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqsa_ctrl: request sequencer
// accepts a request, walks the slot scan, then waits for the result
// register to free up before committing
// ----------------------------------------------------------------------------
module cqsa_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  cqsa_pkg::dp_status_t status,
    output cqsa_pkg::dp_cmd_t    cmd
);
    import cqsa_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                cmd.start = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.step = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                cmd.commit = status.out_free;
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/cqsa_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqsa_datapath: slot pool, scan accumulators and result register
// one slot is examined per step; commit applies the decision
// ----------------------------------------------------------------------------
module cqsa_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cqsa_pkg::dp_cmd_t             cmd,
    output cqsa_pkg::dp_status_t          status,
    input  logic [cqsa_pkg::S_DATA_W-1:0] s_tdata,
    input  cqsa_pkg::quota_t              quota,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cqsa_pkg::M_DATA_W-1:0] m_tdata
);
    import cqsa_pkg::*;

    // pool
    logic                   slot_valid_reg [POOL_SLOTS];
    logic [KIND_W-1:0]      slot_kind_reg  [POOL_SLOTS];
    logic [HANDLE_BITS-1:0] slot_owner_reg [POOL_SLOTS];
    logic [ORDER_W-1:0]     slot_order_reg [POOL_SLOTS];
    logic [ORDER_W-1:0]     next_order_reg;

    // request
    logic [OP_W-1:0]        op_reg;
    logic [KIND_W-1:0]      kind_reg;
    logic [HANDLE_BITS-1:0] handle_reg;

    // scan
    logic [SLOT_W-1:0]      scan_idx_reg;
    logic [CNT_W-1:0]       live_cnt_reg;
    logic                   oldest_found_reg;
    logic [SLOT_W-1:0]      oldest_idx_reg;
    logic [ORDER_W-1:0]     oldest_order_reg;
    logic [HANDLE_BITS-1:0] oldest_owner_reg;
    logic                   free_found_reg;
    logic [SLOT_W-1:0]      free_idx_reg;
    logic                   match_found_reg;
    logic [SLOT_W-1:0]      match_idx_reg;

    // result
    logic                   m_tvalid_reg;
    logic                   ok_reg;
    logic [SLOT_W-1:0]      slot_index_reg;
    logic                   evicted_reg;
    logic [HANDLE_BITS-1:0] evicted_handle_reg;

    logic                   cur_valid;
    logic                   cur_same_kind;
    logic [QUOTA_W-1:0]     quota_sel;
    logic                   do_evict;
    logic                   alloc_ok;
    logic [SLOT_W-1:0]      alloc_idx;
    logic                   res_ok;
    logic [SLOT_W-1:0]      res_idx;
    logic                   res_evicted;
    logic [HANDLE_BITS-1:0] res_evh;

    assign cur_valid     = slot_valid_reg[scan_idx_reg];
    assign cur_same_kind = cur_valid && (slot_kind_reg[scan_idx_reg] == kind_reg);

    assign status.scan_last = (scan_idx_reg == SLOT_W'(POOL_SLOTS - 1));
    assign status.out_free  = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg           <= s_tdata[OP_W-1:0];
            kind_reg         <= s_tdata[OP_W+KIND_W-1:OP_W];
            handle_reg       <= s_tdata[S_FIELD_W-1:OP_W+KIND_W];
            scan_idx_reg     <= '0;
            live_cnt_reg     <= '0;
            oldest_found_reg <= 1'b0;
            free_found_reg   <= 1'b0;
            match_found_reg  <= 1'b0;
        end else if (cmd.step) begin
            scan_idx_reg <= scan_idx_reg + SLOT_W'(1);
            if (!cur_valid && !free_found_reg) begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= scan_idx_reg;
            end
            if (cur_same_kind) begin
                live_cnt_reg <= live_cnt_reg + CNT_W'(1);
                if (!oldest_found_reg || slot_order_reg[scan_idx_reg] < oldest_order_reg) begin
                    oldest_found_reg <= 1'b1;
                    oldest_idx_reg   <= scan_idx_reg;
                    oldest_order_reg <= slot_order_reg[scan_idx_reg];
                    oldest_owner_reg <= slot_owner_reg[scan_idx_reg];
                end
            end
            if (cur_valid && slot_owner_reg[scan_idx_reg] == handle_reg && !match_found_reg) begin
                match_found_reg <= 1'b1;
                match_idx_reg   <= scan_idx_reg;
            end
        end
    end

    always_comb begin
        case (kind_reg)
            KIND_BLOCK:    quota_sel = quota.block;
            KIND_PLATFORM: quota_sel = quota.platform;
            default:       quota_sel = quota.statue;
        endcase
    end

    assign do_evict  = oldest_found_reg && (CMP_W'(live_cnt_reg) >= CMP_W'(quota_sel));
    assign alloc_ok  = (kind_reg != KIND_NONE) && (do_evict || free_found_reg);
    assign alloc_idx = do_evict ? oldest_idx_reg : free_idx_reg;

    always_comb begin
        res_ok      = 1'b0;
        res_idx     = '0;
        res_evicted = 1'b0;
        res_evh     = '0;
        case (op_reg) inside
            OP_ALLOC: begin
                if (alloc_ok) begin
                    res_ok      = 1'b1;
                    res_idx     = alloc_idx;
                    res_evicted = do_evict;
                    res_evh     = do_evict ? oldest_owner_reg : '0;
                end
            end
            OP_RELEASE, OP_QUERY: begin
                if (match_found_reg) begin
                    res_ok  = 1'b1;
                    res_idx = match_idx_reg;
                end
            end
            default: begin
                res_ok = 1'b0;
            end
        endcase
    end

    // slot payload, written on grant only
    always_ff @(posedge aclk) begin
        if (cmd.commit && op_reg == OP_ALLOC && alloc_ok) begin
            slot_kind_reg[alloc_idx]  <= kind_reg;
            slot_owner_reg[alloc_idx] <= handle_reg;
            slot_order_reg[alloc_idx] <= next_order_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < POOL_SLOTS; i++) begin
                slot_valid_reg[i] <= 1'b0;
            end
            next_order_reg <= '0;
        end else if (cmd.commit) begin
            case (op_reg)
                OP_ALLOC: begin
                    if (alloc_ok) begin
                        slot_valid_reg[alloc_idx] <= 1'b1;
                        next_order_reg            <= next_order_reg + ORDER_W'(1);
                    end
                end
                OP_RELEASE: begin
                    if (match_found_reg) begin
                        slot_valid_reg[match_idx_reg] <= 1'b0;
                    end
                end
                OP_CLEAR: begin
                    for (int i = 0; i < POOL_SLOTS; i++) begin
                        slot_valid_reg[i] <= 1'b0;
                    end
                    next_order_reg <= '0;
                end
                default: begin
                    next_order_reg <= next_order_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            ok_reg             <= res_ok;
            slot_index_reg     <= res_idx;
            evicted_reg        <= res_evicted;
            evicted_handle_reg <= res_evh;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_DATA_W'({evicted_handle_reg, evicted_reg, slot_index_reg, ok_reg});

`ifndef SYNTH
    a_fail_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !ok_reg |-> slot_index_reg == '0 && !evicted_reg
                                    && evicted_handle_reg == '0)
        else $error("failed result carries nonzero fields");

    a_evict_needs_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && evicted_reg |-> ok_reg)
        else $error("eviction reported without a grant");

    a_clear_resets_order: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit && op_reg == OP_CLEAR |=> next_order_reg == '0 && !slot_valid_reg[0])
        else $error("clear all left pool state behind");

    a_commit_into_free_reg: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> !m_tvalid_reg || m_tready)
        else $error("result overwritten before it was taken");
`endif

endmodule

FILE: bench/quota_alloc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quota_alloc_checker: result predictor and comparator for the allocator
// watches the request, result and register channels, keeps its own copy of
// the slot pool and the quotas, and compares every result beat field by field
// ----------------------------------------------------------------------------
module quota_alloc_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [cqsa_pkg::S_DATA_W-1:0]     s_tdata,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [cqsa_pkg::M_DATA_W-1:0]     m_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cqsa_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [cqsa_pkg::APB_DATA_W-1:0]   pwdata,
    input  logic [cqsa_pkg::APB_DATA_W-1:0]   prdata,
    input  logic                              pready,
    output int                                mismatches,
    output int                                outstanding,
    output int                                results_seen,
    output int                                evictions_seen,
    output int                                order_wraps
);
    import cqsa_pkg::*;

    // same layout as the result beat, ok in the lowest bit
    typedef struct packed {
        logic [HANDLE_BITS-1:0] evicted_handle;
        logic                   evicted;
        logic [SLOT_W-1:0]      slot_index;
        logic                   ok;
    } grant_t;

    quota_t                 quotas;
    logic                   held       [POOL_SLOTS];
    logic [KIND_W-1:0]      held_kind  [POOL_SLOTS];
    logic [HANDLE_BITS-1:0] held_owner [POOL_SLOTS];
    logic [ORDER_W-1:0]     held_seq   [POOL_SLOTS];
    logic [ORDER_W-1:0]     seq_next;
    grant_t                 expected_grants [$];

    initial begin
        mismatches     = 0;
        outstanding    = 0;
        results_seen   = 0;
        evictions_seen = 0;
        order_wraps    = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < 40)
            $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    function automatic logic [QUOTA_W-1:0] quota_for(input logic [KIND_W-1:0] kind);
        case (kind)
            KIND_BLOCK:    return quotas.block;
            KIND_PLATFORM: return quotas.platform;
            default:       return quotas.statue;
        endcase
    endfunction

    // applies one request to the pool copy and returns the grant it produces
    function automatic grant_t serve_request(input logic [OP_W-1:0] op,
                                             input logic [KIND_W-1:0] kind,
                                             input logic [HANDLE_BITS-1:0] handle);
        grant_t g;
        int     live;
        int     oldest;
        int     vacant;
        int     pick;
        g      = '0;
        live   = 0;
        oldest = -1;
        vacant = -1;
        pick   = -1;
        if (op == OP_ALLOC) begin
            if (kind == KIND_NONE)
                return g;
            for (int i = 0; i < POOL_SLOTS; i++) begin
                if (!held[i]) begin
                    if (vacant < 0) vacant = i;
                end else if (held_kind[i] == kind) begin
                    live++;
                    if (oldest < 0 || held_seq[i] < held_seq[oldest]) oldest = i;
                end
            end
            if (oldest >= 0 && live >= quota_for(kind)) begin
                pick             = oldest;
                g.evicted        = 1'b1;
                g.evicted_handle = held_owner[oldest];
            end else begin
                pick = vacant;
            end
            if (pick < 0)
                return g;
            held[pick]       = 1'b1;
            held_kind[pick]  = kind;
            held_owner[pick] = handle;
            held_seq[pick]   = seq_next;
            if (seq_next == '1) order_wraps++;
            seq_next     = seq_next + 1'b1;
            g.ok         = 1'b1;
            g.slot_index = SLOT_W'(pick);
        end else if (op == OP_CLEAR) begin
            for (int i = 0; i < POOL_SLOTS; i++) held[i] = 1'b0;
            seq_next = '0;
        end else begin
            // release and query act on the lowest slot holding the handle
            for (int i = 0; i < POOL_SLOTS && pick < 0; i++)
                if (held[i] && held_owner[i] == handle) pick = i;
            if (pick >= 0) begin
                if (op == OP_RELEASE) held[pick] = 1'b0;
                g.ok         = 1'b1;
                g.slot_index = SLOT_W'(pick);
            end
        end
        return g;
    endfunction

    always @(posedge aclk) begin : watch
        grant_t got;
        grant_t want;
        if (!aresetn) begin
            quotas.statue   = QUOTA_STATUE_RST;
            quotas.block    = QUOTA_BLOCK_RST;
            quotas.platform = QUOTA_PLATFORM_RST;
            for (int i = 0; i < POOL_SLOTS; i++) held[i] = 1'b0;
            seq_next = '0;
            expected_grants.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = grant_t'(m_tdata[M_FIELD_W-1:0]);
                results_seen++;
                if (expected_grants.size() == 0) begin
                    report_mismatch("result beat with no request waiting", 32'(m_tdata), 0);
                end else begin
                    want = expected_grants.pop_front();
                    if (want.evicted) evictions_seen++;
                    if (got.ok !== want.ok)
                        report_mismatch("ok", 32'(got.ok), 32'(want.ok));
                    if (got.slot_index !== want.slot_index)
                        report_mismatch("slot_index", 32'(got.slot_index), 32'(want.slot_index));
                    if (got.evicted !== want.evicted)
                        report_mismatch("evicted", 32'(got.evicted), 32'(want.evicted));
                    if (got.evicted_handle !== want.evicted_handle)
                        report_mismatch("evicted_handle", 32'(got.evicted_handle),
                                        32'(want.evicted_handle));
                end
            end
            if (s_tvalid && s_tready)
                expected_grants.push_back(serve_request(s_tdata[OP_W-1:0],
                                                        s_tdata[OP_W +: KIND_W],
                                                        s_tdata[OP_W+KIND_W +: HANDLE_BITS]));
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (paddr[APB_ADDR_W-1:2])
                        REG_QUOTA_STATUE:   quotas.statue   = pwdata[QUOTA_W-1:0];
                        REG_QUOTA_BLOCK:    quotas.block    = pwdata[QUOTA_W-1:0];
                        REG_QUOTA_PLATFORM: quotas.platform = pwdata[QUOTA_W-1:0];
                        default: ;
                    endcase
                end else if (prdata[QUOTA_W-1:0] !== quota_for(paddr[APB_ADDR_W-1:2])) begin
                    report_mismatch("quota readback", 32'(prdata[QUOTA_W-1:0]),
                                    32'(quota_for(paddr[APB_ADDR_W-1:2])));
                end
            end
        end
        outstanding = expected_grants.size();
    end

endmodule

FILE: bench/tb_class_quota_slot_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_class_quota_slot_allocator_unit: stimulus and verdict for the allocator
// drives directed and random requests under several quota settings, with
// bursty request traffic and a stalling result sink, plus a flat-out
// allocation run after a clear; checking is in the checker
// ----------------------------------------------------------------------------
module tb_class_quota_slot_allocator_unit;
    import cqsa_pkg::*;

    // random request beats spread over the quota phases
    localparam int RANDOM_BEATS   = 1860;
    localparam int QUOTA_PHASES   = 10;
    // back-to-back allocations after a clear
    localparam int FILL_BEATS     = 32;
    localparam int TAIL_BEATS     = 64;
    // longest quiet stretch: sender gap, sink stall and one request's trip through
    // the block, or a drain plus six register transfers; the limit is many times that
    localparam int WATCHDOG_LIMIT = 2000;
    // settle time after the final drain
    localparam int SETTLE_CYCLES  = 2 * (POOL_SLOTS + 2);

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata;     // op[1:0], kind[3:2], handle[19:4], zero pad
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_DATA_W-1:0]    m_tdata;     // ok[0], slot_index[3:1], evicted[4],
                                         // evicted_handle[20:5], zero pad
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    int mismatches;
    int outstanding;
    int results_seen;
    int evictions_seen;
    int order_wraps;
    int beats_sent;
    int quota_settings;

    // sink and source behavior, switched per phase
    bit rx_always_ready;
    bit tx_no_gaps;

    // small handle set per phase so that releases and queries hit and
    // duplicate owners show up
    logic [HANDLE_BITS-1:0] hot_handles [12];

    always #4 aclk = ~aclk;

    class_quota_slot_allocator_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    quota_alloc_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .results_seen   (results_seen),
        .evictions_seen (evictions_seen),
        .order_wraps    (order_wraps)
    );

    // one request beat; valid stays high into the next call within a burst
    task automatic send_beat(input logic [OP_W-1:0] op, input logic [KIND_W-1:0] kind,
                             input logic [HANDLE_BITS-1:0] handle);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'({handle, kind, op});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        beats_sent++;
    endtask

    // drop valid and stay quiet for a while
    task automatic hold_off(input int cycles);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        repeat (cycles) @(negedge aclk);
    endtask

    // stop sending until every expected result beat has come back
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
    endtask

    // setup cycle then access cycle; pready is sampled at the rising edge
    task automatic apb_access(input bit write, input logic [1:0] idx,
                              input logic [APB_DATA_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // write all three quotas with junk in the unused upper bits, then read
    // them back so the checker sees the stored values
    task automatic set_quotas(input logic [QUOTA_W-1:0] statue, input logic [QUOTA_W-1:0] block,
                              input logic [QUOTA_W-1:0] platform);
        logic [APB_DATA_W-1:0] junk;
        junk = $urandom;
        apb_access(1'b1, REG_QUOTA_STATUE, {junk[APB_DATA_W-1:QUOTA_W], statue});
        junk = $urandom;
        apb_access(1'b1, REG_QUOTA_BLOCK, {junk[APB_DATA_W-1:QUOTA_W], block});
        junk = $urandom;
        apb_access(1'b1, REG_QUOTA_PLATFORM, {junk[APB_DATA_W-1:QUOTA_W], platform});
        apb_access(1'b0, REG_QUOTA_STATUE, '0);
        apb_access(1'b0, REG_QUOTA_BLOCK, '0);
        apb_access(1'b0, REG_QUOTA_PLATFORM, '0);
        quota_settings++;
    endtask

    // mostly allocations against a small handle set, with releases and
    // queries that usually hit, an occasional clear and some kind-three noise
    task automatic random_beat(input bit allow_clear, input bit alloc_only);
        int unsigned           roll;
        logic [OP_W-1:0]       op;
        logic [KIND_W-1:0]     kind;
        logic [HANDLE_BITS-1:0] handle;
        roll = $urandom_range(0, 99);
        if (alloc_only || roll < 52)
            op = OP_ALLOC;
        else if (roll < 72)
            op = OP_RELEASE;
        else if (roll < 97 || !allow_clear)
            op = OP_QUERY;
        else
            op = OP_CLEAR;
        if (!alloc_only && $urandom_range(0, 19) == 0)
            kind = KIND_NONE;
        else
            kind = KIND_W'($urandom_range(0, 2));
        if (!alloc_only && $urandom_range(0, 4) != 0)
            handle = hot_handles[$urandom_range(0, 11)];
        else
            handle = HANDLE_BITS'($urandom);
        send_beat(op, kind, handle);
    endtask

    // result sink: ready runs with short or long stalls between them,
    // or always ready when the phase asks for it
    initial begin : result_sink
        int run_len;
        int stall_len;
        m_tready = 1'b0;
        forever begin
            run_len   = $urandom_range(1, 24);
            if (rx_always_ready)
                stall_len = 0;
            else if ($urandom_range(0, 3) == 0)
                stall_len = $urandom_range(8, 30);
            else
                stall_len = $urandom_range(0, 3);
            repeat (run_len) begin
                @(negedge aclk);
                m_tready <= 1'b1;
            end
            repeat (stall_len) begin
                @(negedge aclk);
                m_tready <= 1'b0;
            end
        end
    end

    // watchdog: a long stretch with no beat on either channel ends the run
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        int                 per_phase;
        int                 sent;
        int                 burst;
        int                 gap;
        logic [QUOTA_W-1:0] q_statue;
        logic [QUOTA_W-1:0] q_block;
        logic [QUOTA_W-1:0] q_platform;

        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        beats_sent      = 0;
        quota_settings  = 0;
        rx_always_ready = 1'b0;
        tx_no_gaps      = 1'b0;

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // reset quotas read back before anything is written
        apb_access(1'b0, REG_QUOTA_STATUE, '0);
        apb_access(1'b0, REG_QUOTA_BLOCK, '0);
        apb_access(1'b0, REG_QUOTA_PLATFORM, '0);

        // directed part under the reset quotas (statue 2, block 3, platform 3)
        send_beat(OP_ALLOC, KIND_STATUE, 16'h0000);
        send_beat(OP_ALLOC, KIND_STATUE, 16'hFFFF);
        // statue quota reached: the oldest statue is evicted and reused
        send_beat(OP_ALLOC, KIND_STATUE, 16'h1234);
        send_beat(OP_QUERY, KIND_STATUE, 16'hFFFF);
        // misses give an all-zero beat; the first release of 0xFFFF hits
        send_beat(OP_QUERY, KIND_BLOCK, 16'hBEEF);
        send_beat(OP_RELEASE, KIND_PLATFORM, 16'hFFFF);
        send_beat(OP_RELEASE, KIND_NONE, 16'hFFFF);
        // kind three has no meaning and must fail without touching the pool
        send_beat(OP_ALLOC, KIND_NONE, 16'h5555);
        // duplicate owners: release and query pick the lowest slot
        send_beat(OP_ALLOC, KIND_BLOCK, 16'h0042);
        send_beat(OP_ALLOC, KIND_BLOCK, 16'h0042);
        send_beat(OP_QUERY, KIND_BLOCK, 16'h0042);
        send_beat(OP_RELEASE, KIND_BLOCK, 16'h0042);
        send_beat(OP_QUERY, KIND_BLOCK, 16'h0042);
        send_beat(OP_ALLOC, KIND_PLATFORM, 16'hAAAA);
        // clear all empties the pool and restarts the sequence counter
        send_beat(OP_CLEAR, KIND_STATUE, 16'hFFFF);
        send_beat(OP_QUERY, KIND_STATUE, 16'hAAAA);

        // zero quotas and a full quota for platforms
        wait_drained();
        set_quotas(4'd0, 4'd0, 4'd8);
        // quota zero with nothing live: a free slot is taken
        send_beat(OP_ALLOC, KIND_STATUE, 16'h0001);
        // quota zero with one live: that one is evicted
        send_beat(OP_ALLOC, KIND_STATUE, 16'h0002);
        for (int i = 0; i < POOL_SLOTS - 1; i++)
            send_beat(OP_ALLOC, KIND_PLATFORM, HANDLE_BITS'(16'h0100 + i));
        // pool full, platform quota not reached: both requests fail
        send_beat(OP_ALLOC, KIND_BLOCK, 16'h0BAD);
        send_beat(OP_ALLOC, KIND_PLATFORM, 16'h0BAD);

        // random part, one quota setting per phase, extremes first
        per_phase = RANDOM_BEATS / QUOTA_PHASES;
        for (int phase = 0; phase < QUOTA_PHASES; phase++) begin
            // every phase starts from an idle block
            wait_drained();
            case (phase)
                0:       begin q_statue = 4'd8;  q_block = 4'd8; q_platform = 4'd8; end
                1:       begin q_statue = 4'd0;  q_block = 4'd0; q_platform = 4'd0; end
                2:       begin q_statue = 4'd15; q_block = 4'd8; q_platform = 4'd0; end
                3:       begin q_statue = 4'd1;  q_block = 4'd1; q_platform = 4'd1; end
                default: begin
                    q_statue   = QUOTA_W'($urandom_range(0, 8));
                    q_block    = QUOTA_W'($urandom_range(0, 8));
                    q_platform = QUOTA_W'($urandom_range(0, 8));
                end
            endcase
            set_quotas(q_statue, q_block, q_platform);

            hot_handles[0] = '0;
            hot_handles[1] = '1;
            for (int i = 2; i < 12; i++) hot_handles[i] = HANDLE_BITS'($urandom);

            // every fourth phase runs flat out on both sides
            tx_no_gaps      = (phase % 4 == 3);
            rx_always_ready = (phase % 4 == 3);

            sent = 0;
            while (sent < per_phase) begin
                burst = $urandom_range(1, 16);
                for (int b = 0; b < burst && sent < per_phase; b++) begin
                    random_beat(1'b1, 1'b0);
                    sent++;
                end
                // now and then let the pipeline run completely dry
                if ($urandom_range(0, 99) == 0) begin
                    wait_drained();
                end else if (!tx_no_gaps) begin
                    gap = $urandom_range(0, 12);
                    if (gap != 0) hold_off(gap - 1);
                end
            end
        end

        // back to the reset quotas, clear, then allocations back to back so
        // the pool fills and keeps evicting the oldest of each kind
        wait_drained();
        set_quotas(QUOTA_STATUE_RST, QUOTA_BLOCK_RST, QUOTA_PLATFORM_RST);
        tx_no_gaps      = 1'b1;
        rx_always_ready = 1'b1;
        send_beat(OP_CLEAR, KIND_STATUE, '0);
        for (int i = 0; i < FILL_BEATS; i++)
            random_beat(1'b0, 1'b1);

        // mixed traffic on the refilled pool, idling back on
        tx_no_gaps      = 1'b0;
        rx_always_ready = 1'b0;
        for (int i = 0; i < TAIL_BEATS; i++) begin
            random_beat(1'b0, 1'b0);
            if ($urandom_range(0, 3) == 0) hold_off($urandom_range(0, 6));
        end

        // let everything come back, then give stray beats a chance to show
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("covered %0d request beats over %0d quota settings, %0d result beats",
                 beats_sent, quota_settings, results_seen);
        $display("evictions: %0d, sequence counter wraps: %0d, mismatches: %0d",
                 evictions_seen, order_wraps, mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/cqsa_pkg.sv
rtl/cqsa_ctrl.sv
rtl/cqsa_datapath.sv
rtl/class_quota_slot_allocator_unit.sv
bench/quota_alloc_checker.sv
bench/tb_class_quota_slot_allocator_unit.sv
